// ===== src/yuv_pkg.sv =====
package yuv_pkg;

    // Counter width default and the fixed width of the line limit registers
    localparam int COUNT_BITS_DEF = 12;
    localparam int LIMIT_BITS     = 12;

    // Configuration port
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CR_TO_RED   = 3'd0,
        REG_CB_TO_GREEN = 3'd1,
        REG_CR_TO_GREEN = 3'd2,
        REG_CB_TO_BLUE  = 3'd3,
        REG_LINE_WIDTH  = 3'd4,
        REG_LINE_COUNT  = 3'd5
    } cfg_index_t;

    // Register reset values: Q2.14 / Q3.14 weights and frame geometry
    localparam logic signed [15:0] CR_TO_RED_RST   = 16'sd18678;
    localparam logic signed [15:0] CB_TO_GREEN_RST = -16'sd6472;
    localparam logic signed [15:0] CR_TO_GREEN_RST = -16'sd9519;
    localparam logic signed [16:0] CB_TO_BLUE_RST  = 17'sd33292;
    localparam logic [LIMIT_BITS-1:0] LINE_WIDTH_RST = 12'd640;
    localparam logic [LIMIT_BITS-1:0] LINE_COUNT_RST = 12'd480;

    // Video offsets
    localparam logic [8:0] LUMA_OFFSET   = 9'd16;
    localparam logic [8:0] CHROMA_OFFSET = 9'd128;

    // Product and sum widths
    localparam int FRAC_BITS = 14;
    localparam int RED_W     = 25;
    localparam int GREEN_W   = 26;
    localparam int BLUE_W    = 26;
    localparam int BASE_W    = 9 + FRAC_BITS;
    localparam int SUM_W     = 27;

    // Position of a byte within a 4:2:2 group
    typedef enum logic [1:0] {
        PH_LUMA_ONE    = 2'd0,
        PH_RED_CHROMA  = 2'd1,
        PH_LUMA_ZERO   = 2'd2,
        PH_BLUE_CHROMA = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       frame_start;
    } byte_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       pair_last;
        logic       line_end;
        logic       frame_end;
    } pixel_t;

    // Line/frame marks for both pixels of a pair
    typedef struct packed {
        logic line_end0;
        logic frame_end0;
        logic line_end1;
        logic frame_end1;
    } pair_marks_t;

    // Divide by 2^14 and clamp to 0..255; negative sums go to zero either way
    function automatic logic [7:0] clamp_pixel(input logic signed [SUM_W-1:0] sum);
        logic [7:0] res;
        if (sum[SUM_W-1]) begin
            res = 8'd0;
        end else if (|sum[SUM_W-2:FRAC_BITS+8]) begin
            res = 8'hFF;
        end else begin
            res = sum[FRAC_BITS+7:FRAC_BITS];
        end
        return res;
    endfunction

endpackage

// ===== src/yuv_cnt_step.sv =====
module yuv_cnt_step #(
    parameter int COUNT_BITS = yuv_pkg::COUNT_BITS_DEF
) (
    input  logic [COUNT_BITS-1:0]          col,
    input  logic [COUNT_BITS-1:0]          row,
    input  logic [yuv_pkg::LIMIT_BITS-1:0] line_width,
    input  logic [yuv_pkg::LIMIT_BITS-1:0] line_count,
    output logic [COUNT_BITS-1:0]          col_next,
    output logic [COUNT_BITS-1:0]          row_next,
    output logic                           line_end,
    output logic                           frame_end
);

    // compare width covers count+1 and the limit register
    localparam int CMP_W = (COUNT_BITS + 1 > yuv_pkg::LIMIT_BITS) ?
                           COUNT_BITS + 1 : yuv_pkg::LIMIT_BITS;

    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] row_inc;

    assign col_inc   = CMP_W'(col) + CMP_W'(1);
    assign row_inc   = CMP_W'(row) + CMP_W'(1);
    assign line_end  = col_inc >= CMP_W'(line_width);
    assign frame_end = line_end && (row_inc >= CMP_W'(line_count));

    always_comb
    begin
        col_next = col_inc[COUNT_BITS-1:0];
        row_next = row;
        if (line_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_inc[COUNT_BITS-1:0];
        end
    end

endmodule

// ===== src/yuv422_stream_to_rgb888.sv =====
// Channel  | Signals                            | Moves per transaction
// ---------+------------------------------------+-------------------------------------
// byte     | byte_valid, byte_ready, byte_data  | one stream byte (Y1, Cr, Y0, Cb)
// rgb      | rgb_valid, rgb_ready, rgb_data     | one RGB888 pixel plus line/frame marks
// cfg      | cfg_write, cfg_index, cfg_data     | one register write, no handshake
//
// One byte can be taken every cycle. A Cb byte closes a group and the pair moves
// through a pair register, a product register (chroma products shared by both
// pixels) and the output register; the Y0 pixel leaves first and the Y1 pixel
// follows it. The two pixels of a pair leave one per cycle while rgb_ready is high.
// Reset (async, rst_n low) clears the pipeline, counters, phase and restores the
// default weights and geometry. A stall on rgb fills the output, product and pair
// registers in turn; byte_ready drops only when the pair register cannot drain.
module yuv422_stream_to_rgb888 #(
    parameter int COUNT_BITS = yuv_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            byte_valid,
    output logic                            byte_ready,
    input  yuv_pkg::byte_t                  byte_data,

    output logic                            rgb_valid,
    input  logic                            rgb_ready,
    output yuv_pkg::pixel_t                 rgb_data,

    input  logic                            cfg_write,
    input  logic [yuv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [yuv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // ---------------- configuration registers ----------------
    logic signed [15:0]              cr_to_red_reg;
    logic signed [15:0]              cb_to_green_reg;
    logic signed [15:0]              cr_to_green_reg;
    logic signed [16:0]              cb_to_blue_reg;
    logic [yuv_pkg::LIMIT_BITS-1:0]  line_width_reg;
    logic [yuv_pkg::LIMIT_BITS-1:0]  line_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_to_red_reg   <= yuv_pkg::CR_TO_RED_RST;
            cb_to_green_reg <= yuv_pkg::CB_TO_GREEN_RST;
            cr_to_green_reg <= yuv_pkg::CR_TO_GREEN_RST;
            cb_to_blue_reg  <= yuv_pkg::CB_TO_BLUE_RST;
            line_width_reg  <= yuv_pkg::LINE_WIDTH_RST;
            line_count_reg  <= yuv_pkg::LINE_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                yuv_pkg::REG_CR_TO_RED:   cr_to_red_reg   <= $signed(cfg_data[15:0]);
                yuv_pkg::REG_CB_TO_GREEN: cb_to_green_reg <= $signed(cfg_data[15:0]);
                yuv_pkg::REG_CR_TO_GREEN: cr_to_green_reg <= $signed(cfg_data[15:0]);
                yuv_pkg::REG_CB_TO_BLUE:  cb_to_blue_reg  <= $signed(cfg_data[16:0]);
                yuv_pkg::REG_LINE_WIDTH:
                    line_width_reg <= cfg_data[yuv_pkg::LIMIT_BITS-1:0];
                yuv_pkg::REG_LINE_COUNT:
                    line_count_reg <= cfg_data[yuv_pkg::LIMIT_BITS-1:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // ---------------- byte capture ----------------
    yuv_pkg::phase_t         phase_reg, phase_next, phase_eff;
    logic [7:0]              y1_reg, cr_hold_reg, y0_reg;
    logic [COUNT_BITS-1:0]   col_reg, col_next, col_eff;
    logic [COUNT_BITS-1:0]   row_reg, row_next, row_eff;
    logic [COUNT_BITS-1:0]   col_mid, row_mid, col_end, row_end;
    yuv_pkg::pair_marks_t    marks;
    logic                    byte_acc;
    logic                    pair_load;

    // pipeline handshake
    logic p_valid_reg, p_valid_next, p_move;
    logic m_valid_reg, m_valid_next, m_sel_reg, m_sel_next;
    logic o_valid_reg, o_valid_next, o_load;

    assign byte_acc  = byte_valid && byte_ready;
    // frame start realigns phase and counters before the byte is taken
    assign phase_eff = byte_data.frame_start ? yuv_pkg::PH_LUMA_ONE : phase_reg;
    assign col_eff   = byte_data.frame_start ? '0 : col_reg;
    assign row_eff   = byte_data.frame_start ? '0 : row_reg;
    assign pair_load = byte_acc && (phase_eff == yuv_pkg::PH_BLUE_CHROMA);

    // counter marks for the Y0 pixel, then for the Y1 pixel
    yuv_cnt_step #(.COUNT_BITS(COUNT_BITS)) u_step_zero (
        .col        (col_eff),
        .row        (row_eff),
        .line_width (line_width_reg),
        .line_count (line_count_reg),
        .col_next   (col_mid),
        .row_next   (row_mid),
        .line_end   (marks.line_end0),
        .frame_end  (marks.frame_end0)
    );

    yuv_cnt_step #(.COUNT_BITS(COUNT_BITS)) u_step_one (
        .col        (col_mid),
        .row        (row_mid),
        .line_width (line_width_reg),
        .line_count (line_count_reg),
        .col_next   (col_end),
        .row_next   (row_end),
        .line_end   (marks.line_end1),
        .frame_end  (marks.frame_end1)
    );

    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (byte_acc)
        begin
            col_next = col_eff;
            row_next = row_eff;
            unique case (phase_eff)
                yuv_pkg::PH_LUMA_ONE:   phase_next = yuv_pkg::PH_RED_CHROMA;
                yuv_pkg::PH_RED_CHROMA: phase_next = yuv_pkg::PH_LUMA_ZERO;
                yuv_pkg::PH_LUMA_ZERO:  phase_next = yuv_pkg::PH_BLUE_CHROMA;
                default:
                begin
                    phase_next = yuv_pkg::PH_LUMA_ONE;
                    col_next   = col_end;
                    row_next   = row_end;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= yuv_pkg::PH_LUMA_ONE;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_acc)
        begin
            case (phase_eff)
                yuv_pkg::PH_LUMA_ONE:   y1_reg      <= byte_data.pixel_byte;
                yuv_pkg::PH_RED_CHROMA: cr_hold_reg <= byte_data.pixel_byte;
                yuv_pkg::PH_LUMA_ZERO:  y0_reg      <= byte_data.pixel_byte;
                default: ;
            endcase
        end
    end

    // ---------------- pair register ----------------
    logic [7:0]           p_y0_reg, p_y1_reg, p_cr_reg, p_cb_reg;
    yuv_pkg::pair_marks_t p_marks_reg;

    assign p_move       = p_valid_reg && (!m_valid_reg || (o_load && m_sel_reg));
    assign byte_ready   = !p_valid_reg || p_move;
    assign p_valid_next = pair_load ? 1'b1 : (p_move ? 1'b0 : p_valid_reg);

    always_ff @(posedge clk)
    begin
        if (pair_load)
        begin
            p_y0_reg    <= y0_reg;
            p_y1_reg    <= y1_reg;
            p_cr_reg    <= cr_hold_reg;
            p_cb_reg    <= byte_data.pixel_byte;
            p_marks_reg <= marks;
        end
    end

    // ---------------- chroma products, shared by both pixels ----------------
    logic signed [8:0]                   cr_s, cb_s;
    logic signed [yuv_pkg::RED_W-1:0]    red_prod;
    logic signed [yuv_pkg::GREEN_W-1:0]  green_prod;
    logic signed [yuv_pkg::BLUE_W-1:0]   blue_prod;

    assign cr_s       = $signed({1'b0, p_cr_reg} - yuv_pkg::CHROMA_OFFSET);
    assign cb_s       = $signed({1'b0, p_cb_reg} - yuv_pkg::CHROMA_OFFSET);
    assign red_prod   = cr_to_red_reg * cr_s;
    assign green_prod = cb_to_green_reg * cb_s + cr_to_green_reg * cr_s;
    assign blue_prod  = cb_to_blue_reg * cb_s;

    logic [7:0]                          m_y0_reg, m_y1_reg;
    yuv_pkg::pair_marks_t                m_marks_reg;
    logic signed [yuv_pkg::RED_W-1:0]    m_red_reg;
    logic signed [yuv_pkg::GREEN_W-1:0]  m_green_reg;
    logic signed [yuv_pkg::BLUE_W-1:0]   m_blue_reg;

    // m_sel_reg: 0 while the Y0 pixel is pending, 1 for the Y1 pixel
    assign m_valid_next = p_move ? 1'b1 : ((o_load && m_sel_reg) ? 1'b0 : m_valid_reg);
    assign m_sel_next   = p_move ? 1'b0 : (o_load ? ~m_sel_reg : m_sel_reg);

    always_ff @(posedge clk)
    begin
        if (p_move)
        begin
            m_y0_reg    <= p_y0_reg;
            m_y1_reg    <= p_y1_reg;
            m_marks_reg <= p_marks_reg;
            m_red_reg   <= red_prod;
            m_green_reg <= green_prod;
            m_blue_reg  <= blue_prod;
        end
    end

    // ---------------- per-pixel sum, scale and clamp ----------------
    logic [7:0]                        pix_y;
    logic signed [8:0]                 y_s;
    logic signed [yuv_pkg::BASE_W-1:0] base;
    logic signed [yuv_pkg::SUM_W-1:0]  red_sum, green_sum, blue_sum;
    yuv_pkg::pixel_t                   pix_next;
    yuv_pkg::pixel_t                   o_data_reg;

    assign pix_y     = m_sel_reg ? m_y1_reg : m_y0_reg;
    assign y_s       = $signed({1'b0, pix_y} - yuv_pkg::LUMA_OFFSET);
    assign base      = $signed({y_s, {yuv_pkg::FRAC_BITS{1'b0}}});
    assign red_sum   = yuv_pkg::SUM_W'(base) + yuv_pkg::SUM_W'(m_red_reg);
    assign green_sum = yuv_pkg::SUM_W'(base) + yuv_pkg::SUM_W'(m_green_reg);
    assign blue_sum  = yuv_pkg::SUM_W'(base) + yuv_pkg::SUM_W'(m_blue_reg);

    always_comb
    begin
        pix_next.red       = yuv_pkg::clamp_pixel(red_sum);
        pix_next.green     = yuv_pkg::clamp_pixel(green_sum);
        pix_next.blue      = yuv_pkg::clamp_pixel(blue_sum);
        pix_next.pair_last = m_sel_reg;
        pix_next.line_end  = m_sel_reg ? m_marks_reg.line_end1  : m_marks_reg.line_end0;
        pix_next.frame_end = m_sel_reg ? m_marks_reg.frame_end1 : m_marks_reg.frame_end0;
    end

    // ---------------- output register ----------------
    assign o_load       = m_valid_reg && (!o_valid_reg || rgb_ready);
    assign o_valid_next = o_load ? 1'b1 : (rgb_ready ? 1'b0 : o_valid_reg);

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            o_data_reg <= pix_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            m_sel_reg   <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
            m_sel_reg   <= m_sel_next;
            o_valid_reg <= o_valid_next;
        end
    end

    assign rgb_valid = o_valid_reg;
    assign rgb_data  = o_data_reg;

endmodule

// ===== src/yuv_checker.sv =====
module yuv_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            rgb_valid,
    input logic            rgb_ready,
    input yuv_pkg::pixel_t rgb_data
);

    // a frame end is always also a line end
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_data.frame_end |-> rgb_data.line_end)
        else $error("frame_end without line_end");

    // once a Y0 pixel is taken, its Y1 pixel is shown in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_ready && !rgb_data.pair_last |=> rgb_valid && rgb_data.pair_last)
        else $error("Y1 pixel did not follow Y0 pixel");

    // after a Y1 pixel the next pixel shown opens a new pair
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_ready && rgb_data.pair_last |=> !(rgb_valid && rgb_data.pair_last))
        else $error("two Y1 pixels in a row");

    // stalled pixel holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb_data))
        else $error("stalled pixel changed");

endmodule

bind yuv422_stream_to_rgb888 yuv_checker u_yuv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb_data  (rgb_data)
);
